@@ rtl/core/vmos_pkg.sv @@
// Shared types and constants for the interpreter operand stack with block frames.
// Used by vmos_ctrl, vmos_dp and vm_operand_stack_with_frames; depends on nothing.
package vmos_pkg;

    localparam int VALUE_DEPTH  = 256;
    localparam int FRAME_DEPTH  = 32;
    localparam int MAX_POP_MANY = 16;

    localparam int VAL_AW = $clog2(VALUE_DEPTH);
    localparam int VAL_CW = $clog2(VALUE_DEPTH + 1);
    localparam int FRM_AW = $clog2(FRAME_DEPTH);
    localparam int FRM_CW = $clog2(FRAME_DEPTH + 1);
    localparam int REM_W  = 5;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 96;

    // Operation codes.
    localparam logic [2:0] OP_PUSH     = 3'd0;
    localparam logic [2:0] OP_POP      = 3'd1;
    localparam logic [2:0] OP_PEEK     = 3'd2;
    localparam logic [2:0] OP_POP_MANY = 3'd3;
    localparam logic [2:0] OP_PUSH_FRM = 3'd4;
    localparam logic [2:0] OP_POP_FRM  = 3'd5;
    localparam logic [2:0] OP_UNWIND   = 3'd6;

    // Result status codes.
    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_UNDERFLOW = 3'd1;
    localparam logic [2:0] ST_BAD_PEEK  = 3'd2;
    localparam logic [2:0] ST_NO_FRAME  = 3'd3;
    localparam logic [2:0] ST_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic              handler;
        logic [30:0]       target;
        logic [VAL_CW-1:0] base;
    } frm_ent_t;

    typedef struct packed {
        logic       accept;
        logic       emit;
        logic [2:0] emit_status;
        logic       emit_read;
        logic       emit_idx;
        logic       emit_frame;
        logic       emit_last;
        logic       val_push;
        logic       val_pop;
        logic       val_rd;
        logic       rd_peek;
        logic       fill_step;
        logic       pm_load;
        logic       pm_step;
        logic       frm_push;
        logic       frm_rd;
        logic       frm_take;
    } cmd_t;

    typedef struct packed {
        logic [2:0] op;
        logic       vfull;
        logic       vempty;
        logic       peek_bad;
        logic       cnt_zero;
        logic       cnt_bad;
        logic       ffull;
        logic       fempty;
        logic       hc_zero;
        logic       out_free;
        logic       rem_one;
        logic       frm_handler;
        logic       fill_need;
    } stat_t;

endpackage

@@ rtl/core/vm_operand_stack_with_frames.sv @@
// Sequence: push, push frame, errors and unknown codes give their registered result from the
// execute state; pop and peek first read the value memory, and pop many reads, then emits one
// value per cycle while the result side is free. Pop frame reads and takes the frame, then
// zero-fills slot by slot; unwind repeats the read and take for each extra frame. One request
// at a time, taken only in the idle state; the result register frees the input side.
// Reset: synchronous, active low; clears the depths, handler count and controller, no memory pass.
module vm_operand_stack_with_frames (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // push_value, peek_offset, pop_count, jump_target, handler_flag, zero fill
    input  logic [vmos_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [2:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // read_value, dest_index, frame_target, frame_is_handler, frame_base,
    // handlers_live, value_depth_now, zero fill
    output logic [vmos_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast
);

    vmos_pkg::cmd_t  cmd;
    vmos_pkg::stat_t stat;

    vmos_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    vmos_dp u_dp (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .stat     (stat),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready)
    );

endmodule

@@ rtl/core/vmos_dp.sv @@
// Datapath of the operand stack: request latch, value and frame memories, depth
// counters and the result register. Depends on vmos_pkg; driven by vmos_ctrl.
module vmos_dp (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  vmos_pkg::cmd_t                  cmd,
    output vmos_pkg::stat_t                 stat,
    // push_value, peek_offset, pop_count, jump_target, handler_flag, zero fill
    input  logic [vmos_pkg::S_TDATA_W-1:0]  s_tdata,
    // operation
    input  logic [2:0]                      s_tuser,
    // read_value, dest_index, frame_target, frame_is_handler, frame_base,
    // handlers_live, value_depth_now, zero fill
    output logic [vmos_pkg::M_TDATA_W-1:0]  m_tdata,
    // status
    output logic [2:0]                      m_tuser,
    output logic                            m_tlast,
    output logic                            m_tvalid,
    input  logic                            m_tready
);

    // Latched request.
    logic [2:0]                   op_reg;
    logic [31:0]                  pv_reg;
    logic [8:0]                   off_reg;
    logic [4:0]                   cnt_reg;
    logic [30:0]                  tgt_reg;
    logic                         hf_reg;

    logic [vmos_pkg::VAL_CW-1:0]  top_reg, top_next;
    logic [vmos_pkg::FRM_CW-1:0]  ftop_reg, ftop_next;
    logic [vmos_pkg::FRM_CW-1:0]  hc_reg, hc_next;
    logic [vmos_pkg::REM_W-1:0]   rem_reg, rem_next;

    logic [31:0]                  rd_data_reg;
    vmos_pkg::frm_ent_t           frm_rd_reg;

    logic                         out_valid_reg;
    logic [vmos_pkg::M_TDATA_W-1:0] out_data_reg;
    logic [2:0]                   out_status_reg;
    logic                         out_last_reg;

    logic [31:0]                  val_mem [vmos_pkg::VALUE_DEPTH];
    vmos_pkg::frm_ent_t           frm_mem [vmos_pkg::FRAME_DEPTH];

    logic [vmos_pkg::VAL_CW-1:0]  rd_ptr;
    logic [vmos_pkg::FRM_CW-1:0]  ftop_m1;
    logic                         val_we;
    logic [31:0]                  val_wdata;
    vmos_pkg::frm_ent_t           frm_wdata;
    logic [31:0]                  o_value;
    logic [3:0]                   o_idx;
    logic [30:0]                  o_tgt;
    logic                         o_hand;
    logic [8:0]                   o_base;

    assign ftop_m1 = ftop_reg - 1'b1;

    // With a pop in the same cycle the next value lies two below the current top.
    always_comb begin
        if (cmd.rd_peek) begin
            rd_ptr = top_reg - vmos_pkg::VAL_CW'(off_reg);
        end else if (cmd.val_pop) begin
            rd_ptr = top_reg - 2'd2;
        end else begin
            rd_ptr = top_reg - 1'b1;
        end
    end

    assign val_we    = cmd.val_push | cmd.fill_step;
    assign val_wdata = cmd.fill_step ? 32'd0 : pv_reg;

    always_comb begin
        frm_wdata.handler = hf_reg;
        frm_wdata.target  = tgt_reg;
        frm_wdata.base    = top_reg;
    end

    always_comb begin
        if (val_we) begin
            top_next = top_reg + 1'b1;
        end else if (cmd.val_pop) begin
            top_next = top_reg - 1'b1;
        end else if (cmd.frm_take && !stat.fill_need) begin
            top_next = frm_rd_reg.base;
        end else begin
            top_next = top_reg;
        end
    end

    always_comb begin
        ftop_next = ftop_reg;
        hc_next   = hc_reg;
        if (cmd.frm_push) begin
            ftop_next = ftop_reg + 1'b1;
            hc_next   = hc_reg + vmos_pkg::FRM_CW'(hf_reg);
        end else if (cmd.frm_take) begin
            ftop_next = ftop_m1;
            if (frm_rd_reg.handler && hc_reg != '0) begin
                hc_next = hc_reg - 1'b1;
            end
        end
    end

    always_comb begin
        if (cmd.pm_load) begin
            rem_next = cnt_reg;
        end else if (cmd.pm_step) begin
            rem_next = rem_reg - 1'b1;
        end else begin
            rem_next = rem_reg;
        end
    end

    always_comb begin
        stat.op          = op_reg;
        stat.vfull       = top_reg == vmos_pkg::VAL_CW'(vmos_pkg::VALUE_DEPTH);
        stat.vempty      = top_reg == '0;
        stat.peek_bad    = (off_reg == '0) || (32'(off_reg) > 32'(top_reg));
        stat.cnt_zero    = cnt_reg == '0;
        stat.cnt_bad     = (32'(cnt_reg) > 32'(vmos_pkg::MAX_POP_MANY))
                           || (32'(cnt_reg) > 32'(top_reg));
        stat.ffull       = ftop_reg == vmos_pkg::FRM_CW'(vmos_pkg::FRAME_DEPTH);
        stat.fempty      = ftop_reg == '0;
        stat.hc_zero     = hc_reg == '0;
        stat.out_free    = !out_valid_reg || m_tready;
        stat.rem_one     = rem_reg == vmos_pkg::REM_W'(1);
        stat.frm_handler = frm_rd_reg.handler;
        stat.fill_need   = frm_rd_reg.base > top_reg;
    end

    always_comb begin
        o_value = cmd.emit_read  ? rd_data_reg : 32'd0;
        o_idx   = cmd.emit_idx   ? 4'(rem_reg - 1'b1) : 4'd0;
        o_tgt   = cmd.emit_frame ? frm_rd_reg.target : 31'd0;
        o_hand  = cmd.emit_frame ? frm_rd_reg.handler : 1'b0;
        o_base  = cmd.emit_frame ? 9'(frm_rd_reg.base) : 9'd0;
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            op_reg  <= s_tuser;
            pv_reg  <= s_tdata[31:0];
            off_reg <= s_tdata[40:32];
            cnt_reg <= s_tdata[45:41];
            tgt_reg <= s_tdata[76:46];
            hf_reg  <= s_tdata[77];
        end
        if (val_we) begin
            val_mem[top_reg[vmos_pkg::VAL_AW-1:0]] <= val_wdata;
        end
        if (cmd.val_rd) begin
            rd_data_reg <= val_mem[rd_ptr[vmos_pkg::VAL_AW-1:0]];
        end
        if (cmd.frm_push) begin
            frm_mem[ftop_reg[vmos_pkg::FRM_AW-1:0]] <= frm_wdata;
        end
        if (cmd.frm_rd) begin
            frm_rd_reg <= frm_mem[ftop_m1[vmos_pkg::FRM_AW-1:0]];
        end
        if (cmd.emit) begin
            out_data_reg   <= {4'd0, 9'(top_next), 6'(hc_next), o_base, o_hand, o_tgt,
                               o_idx, o_value};
            out_status_reg <= cmd.emit_status;
            out_last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_reg       <= '0;
            ftop_reg      <= '0;
            hc_reg        <= '0;
            rem_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            top_reg  <= top_next;
            ftop_reg <= ftop_next;
            hc_reg   <= hc_next;
            rem_reg  <= rem_next;
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_status_reg;
    assign m_tlast  = out_last_reg;
    assign m_tvalid = out_valid_reg;

endmodule

@@ rtl/core/vmos_ctrl.sv @@
// Controller state machine of the operand stack: decodes each request and
// sequences the datapath. Depends on vmos_pkg; drives vmos_dp.
module vmos_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  vmos_pkg::stat_t stat,
    output vmos_pkg::cmd_t  cmd
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_EXEC  = 3'd1;
    localparam logic [2:0] S_RDV   = 3'd2;
    localparam logic [2:0] S_PMANY = 3'd3;
    localparam logic [2:0] S_FRD   = 3'd4;
    localparam logic [2:0] S_FFIN  = 3'd5;

    logic [2:0] state_reg, state_next;
    logic       unwind_done;

    assign s_tready = state_reg == S_IDLE;

    // Pop frame stops after one frame; unwind stops at a handler or an empty frame stack.
    assign unwind_done = (stat.op != vmos_pkg::OP_UNWIND) || stat.frm_handler || stat.fempty;

    always_comb begin
        cmd           = '0;
        cmd.emit_last = 1'b1;
        state_next    = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    cmd.accept = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (stat.op) inside
                    vmos_pkg::OP_PUSH: begin
                        if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = stat.vfull ? vmos_pkg::ST_OVERFLOW
                                                         : vmos_pkg::ST_OK;
                            cmd.val_push    = !stat.vfull;
                            state_next      = S_IDLE;
                        end
                    end
                    vmos_pkg::OP_POP: begin
                        if (!stat.vempty) begin
                            cmd.val_rd = 1'b1;
                            state_next = S_RDV;
                        end else if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = vmos_pkg::ST_UNDERFLOW;
                            state_next      = S_IDLE;
                        end
                    end
                    vmos_pkg::OP_PEEK: begin
                        if (!stat.peek_bad) begin
                            cmd.val_rd  = 1'b1;
                            cmd.rd_peek = 1'b1;
                            state_next  = S_RDV;
                        end else if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = vmos_pkg::ST_BAD_PEEK;
                            state_next      = S_IDLE;
                        end
                    end
                    vmos_pkg::OP_POP_MANY: begin
                        if (!stat.cnt_zero && !stat.cnt_bad) begin
                            cmd.val_rd  = 1'b1;
                            cmd.pm_load = 1'b1;
                            state_next  = S_PMANY;
                        end else if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = stat.cnt_zero ? vmos_pkg::ST_OK
                                                            : vmos_pkg::ST_UNDERFLOW;
                            state_next      = S_IDLE;
                        end
                    end
                    vmos_pkg::OP_PUSH_FRM: begin
                        if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = stat.ffull ? vmos_pkg::ST_OVERFLOW
                                                         : vmos_pkg::ST_OK;
                            cmd.frm_push    = !stat.ffull;
                            state_next      = S_IDLE;
                        end
                    end
                    vmos_pkg::OP_POP_FRM, vmos_pkg::OP_UNWIND: begin
                        if (!stat.fempty &&
                            !(stat.op == vmos_pkg::OP_UNWIND && stat.hc_zero)) begin
                            cmd.frm_rd = 1'b1;
                            state_next = S_FRD;
                        end else if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = vmos_pkg::ST_NO_FRAME;
                            state_next      = S_IDLE;
                        end
                    end
                    default: begin
                        if (stat.out_free) begin
                            cmd.emit        = 1'b1;
                            cmd.emit_status = vmos_pkg::ST_OK;
                            state_next      = S_IDLE;
                        end
                    end
                endcase
            end
            S_RDV: begin
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_read = 1'b1;
                    cmd.val_pop   = stat.op == vmos_pkg::OP_POP;
                    state_next    = S_IDLE;
                end
            end
            S_PMANY: begin
                // One value leaves per cycle while the result register is free; the next read is issued alongside.
                if (stat.out_free) begin
                    cmd.emit      = 1'b1;
                    cmd.emit_read = 1'b1;
                    cmd.emit_idx  = 1'b1;
                    cmd.emit_last = stat.rem_one;
                    cmd.val_pop   = 1'b1;
                    cmd.pm_step   = 1'b1;
                    if (stat.rem_one) begin
                        state_next = S_IDLE;
                    end else begin
                        cmd.val_rd = 1'b1;
                    end
                end
            end
            S_FRD: begin
                cmd.frm_take = 1'b1;
                state_next   = S_FFIN;
            end
            S_FFIN: begin
                // A frame deeper than the stack raises the depth with zeros first.
                if (stat.fill_need) begin
                    cmd.fill_step = 1'b1;
                end else if (!unwind_done) begin
                    cmd.frm_rd = 1'b1;
                    state_next = S_FRD;
                end else if (stat.out_free) begin
                    cmd.emit        = 1'b1;
                    cmd.emit_frame  = 1'b1;
                    cmd.emit_status = (stat.op == vmos_pkg::OP_UNWIND && !stat.frm_handler)
                                      ? vmos_pkg::ST_NO_FRAME : vmos_pkg::ST_OK;
                    state_next      = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

@@ tb/vmos_checker.sv @@
`timescale 1ns / 100ps
// Scoreboard for the operand stack with frames: watches both streams, keeps its own copy of
// the value and frame stacks, and compares every result with the oldest one predicted.
// Depends on vmos_pkg for depths, operation and status codes and the frame entry type.
module vmos_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [vmos_pkg::S_TDATA_W-1:0]  s_tdata,
    input  logic [2:0]                      s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [vmos_pkg::M_TDATA_W-1:0]  m_tdata,
    input  logic [2:0]                      m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              results_owed
);

    typedef struct packed {
        logic [31:0] read_value;
        logic [3:0]  dest_index;
        logic [30:0] frame_target;
        logic        frame_is_handler;
        logic [8:0]  frame_base;
        logic [5:0]  handlers_live;
        logic [8:0]  value_depth;
        logic [2:0]  status;
        logic        last;
    } stack_result_t;

    logic [31:0]          operands [vmos_pkg::VALUE_DEPTH];
    vmos_pkg::frm_ent_t   frames [vmos_pkg::FRAME_DEPTH];
    int unsigned          depth;
    int unsigned          frame_cnt;
    int unsigned          live_handlers;
    int                   mismatches;
    stack_result_t        pending_results [$];

    function automatic stack_result_t make_result(logic [31:0] val, logic [3:0] idx,
                                                  vmos_pkg::frm_ent_t frm, logic [2:0] st,
                                                  logic lst);
        stack_result_t r;
        r.read_value       = val;
        r.dest_index       = idx;
        r.frame_target     = frm.target;
        r.frame_is_handler = frm.handler;
        r.frame_base       = frm.base;
        r.handlers_live    = live_handlers[5:0];
        r.value_depth      = depth[8:0];
        r.status           = st;
        r.last             = lst;
        return r;
    endfunction

    // New predictions go to the back of the queue.
    function automatic void queue_result(stack_result_t r);
        pending_results.insert(pending_results.size(), r);
    endfunction

    // Moving the depth up fills the newly exposed slots with zero.
    function automatic void set_value_depth(int unsigned d);
        if (d > vmos_pkg::VALUE_DEPTH) d = vmos_pkg::VALUE_DEPTH;
        for (int unsigned i = depth; i < d; i++) operands[i] = '0;
        depth = d;
    endfunction

    function automatic vmos_pkg::frm_ent_t remove_frame();
        vmos_pkg::frm_ent_t f;
        frame_cnt--;
        f = frames[frame_cnt];
        if (f.handler && live_handlers > 0) live_handlers--;
        set_value_depth(f.base);
        return f;
    endfunction

    function automatic void apply_stack_op(logic [2:0] op,
                                           logic [vmos_pkg::S_TDATA_W-1:0] word);
        logic [31:0]        push_val;
        logic [8:0]         offset;
        logic [4:0]         count;
        logic [30:0]        target;
        logic               hflag;
        vmos_pkg::frm_ent_t f;
        push_val = word[31:0];
        offset   = word[40:32];
        count    = word[45:41];
        target   = word[76:46];
        hflag    = word[77];
        case (op)
            vmos_pkg::OP_PUSH: begin
                if (depth >= vmos_pkg::VALUE_DEPTH) begin
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_OVERFLOW, 1'b1));
                end else begin
                    operands[depth] = push_val;
                    depth++;
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_OK, 1'b1));
                end
            end
            vmos_pkg::OP_POP: begin
                if (depth == 0) begin
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_UNDERFLOW, 1'b1));
                end else begin
                    depth--;
                    queue_result(make_result(operands[depth], '0, '0, vmos_pkg::ST_OK, 1'b1));
                end
            end
            vmos_pkg::OP_PEEK: begin
                if (offset == 0 || offset > depth) begin
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_BAD_PEEK, 1'b1));
                end else begin
                    queue_result(make_result(operands[depth - offset], '0, '0,
                                             vmos_pkg::ST_OK, 1'b1));
                end
            end
            vmos_pkg::OP_POP_MANY: begin
                if (count == 0) begin
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_OK, 1'b1));
                end else if (count > vmos_pkg::MAX_POP_MANY || count > depth) begin
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_UNDERFLOW, 1'b1));
                end else begin
                    for (int k = 0; k < count; k++) begin
                        depth--;
                        queue_result(make_result(operands[depth], 4'(count - 1 - k), '0,
                                                 vmos_pkg::ST_OK, k + 1 == count));
                    end
                end
            end
            vmos_pkg::OP_PUSH_FRM: begin
                if (frame_cnt >= vmos_pkg::FRAME_DEPTH) begin
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_OVERFLOW, 1'b1));
                end else begin
                    f.base    = depth[vmos_pkg::VAL_CW-1:0];
                    f.target  = target;
                    f.handler = hflag;
                    frames[frame_cnt] = f;
                    frame_cnt++;
                    if (hflag) live_handlers++;
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_OK, 1'b1));
                end
            end
            vmos_pkg::OP_POP_FRM: begin
                if (frame_cnt == 0) begin
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_NO_FRAME, 1'b1));
                end else begin
                    f = remove_frame();
                    queue_result(make_result('0, '0, f, vmos_pkg::ST_OK, 1'b1));
                end
            end
            vmos_pkg::OP_UNWIND: begin
                if (live_handlers == 0 || frame_cnt == 0) begin
                    queue_result(make_result('0, '0, '0, vmos_pkg::ST_NO_FRAME, 1'b1));
                end else begin
                    // Every frame above the handler applies its own depth on the way down.
                    f = remove_frame();
                    while (!f.handler && frame_cnt > 0) f = remove_frame();
                    queue_result(make_result('0, '0, f,
                        f.handler ? vmos_pkg::ST_OK : vmos_pkg::ST_NO_FRAME, 1'b1));
                end
            end
            default: begin
                queue_result(make_result('0, '0, '0, vmos_pkg::ST_OK, 1'b1));
            end
        endcase
    endfunction

    function automatic void compare_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s expected %0h, got %0h", $time, name, want, got);
        end
    endfunction

    always @(posedge aclk) begin : watch
        stack_result_t got;
        stack_result_t want;
        if (!aresetn) begin
            depth         = 0;
            frame_cnt     = 0;
            live_handlers = 0;
            mismatches    = 0;
            pending_results.delete();
        end else begin
            if (m_tvalid && m_tready) begin
                got.read_value       = m_tdata[31:0];
                got.dest_index       = m_tdata[35:32];
                got.frame_target     = m_tdata[66:36];
                got.frame_is_handler = m_tdata[67];
                got.frame_base       = m_tdata[76:68];
                got.handlers_live    = m_tdata[82:77];
                got.value_depth      = m_tdata[91:83];
                got.status           = m_tuser;
                got.last             = m_tlast;
                if (pending_results.size() == 0) begin
                    mismatches++;
                    $display("%0t: result expected none, got status %0d data %h",
                             $time, got.status, m_tdata);
                end else begin
                    want = pending_results.pop_front();
                    compare_field("read_value", want.read_value, got.read_value);
                    compare_field("dest_index", want.dest_index, got.dest_index);
                    compare_field("frame_target", want.frame_target, got.frame_target);
                    compare_field("frame_is_handler", want.frame_is_handler,
                                  got.frame_is_handler);
                    compare_field("frame_base", want.frame_base, got.frame_base);
                    compare_field("handlers_live", want.handlers_live, got.handlers_live);
                    compare_field("value_depth_now", want.value_depth, got.value_depth);
                    compare_field("status", want.status, got.status);
                    compare_field("last", want.last, got.last);
                end
            end
            if (s_tvalid && s_tready) apply_stack_op(s_tuser, s_tdata);
        end
        fail_count   <= mismatches;
        results_owed <= pending_results.size();
    end

endmodule

@@ tb/tb_vm_operand_stack_with_frames.sv @@
`timescale 1ns / 100ps
// Top of the operand stack testbench: clock, reset, request and result stream drivers and
// the verdict. Depends on vmos_pkg, vm_operand_stack_with_frames and vmos_checker.
module tb_vm_operand_stack_with_frames;

    localparam logic [2:0] OP_UNUSED = 3'd7;

    localparam int DIRECTED_ITEMS = 25;
    localparam int RANDOM_ITEMS   = 405;
    localparam int FILL_AFTER     = 60;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 400;
    localparam int IDLE_LIMIT     = 5000;

    logic                            aclk     = 1'b0;
    logic                            aresetn  = 1'b0;
    logic                            s_tvalid = 1'b0;
    logic                            s_tready;
    logic [vmos_pkg::S_TDATA_W-1:0]  s_tdata  = '0;
    logic [2:0]                      s_tuser  = '0;
    logic                            m_tvalid;
    logic                            m_tready = 1'b0;
    logic [vmos_pkg::M_TDATA_W-1:0]  m_tdata;
    logic [2:0]                      m_tuser;
    logic                            m_tlast;

    int fail_count;
    int results_owed;
    int idle_cycles   = 0;
    int hold_requests = 0;
    int requests_sent = 0;
    int burst_left    = 0;

    vm_operand_stack_with_frames dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    vmos_checker u_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .m_tlast      (m_tlast),
        .fail_count   (fail_count),
        .results_owed (results_owed)
    );

    initial begin
        forever #2 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin : watchdog
        wait (idle_cycles >= IDLE_LIMIT);
        $display("vm_operand_stack_with_frames: mismatch");
        $finish;
    end

    // The receiver changes its stall rate every so often; a requested hold keeps it
    // stalled long enough for the block to back up into the request side.
    initial begin : receiver
        int holds_done;
        int pct;
        holds_done = 0;
        forever begin
            case ($urandom_range(0, 3))
                0: pct = 100;
                1: pct = 80;
                2: pct = 50;
                default: pct = 15;
            endcase
            repeat ($urandom_range(20, 200)) begin
                if (hold_requests != holds_done) begin
                    holds_done++;
                    m_tready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge aclk);
                end
                m_tready <= ($urandom_range(1, 100) <= pct);
                @(posedge aclk);
            end
        end
    end

    function automatic logic [vmos_pkg::S_TDATA_W-1:0] pack_req(logic [31:0] val,
                                                                logic [8:0] off,
                                                                logic [4:0] cnt,
                                                                logic [30:0] tgt,
                                                                logic hf);
        logic [vmos_pkg::S_TDATA_W-1:0] w;
        w        = '0;
        w[31:0]  = val;
        w[40:32] = off;
        w[45:41] = cnt;
        w[76:46] = tgt;
        w[77]    = hf;
        return w;
    endfunction

    // Requests go out in bursts; valid drops only between bursts.
    task automatic send_req(logic [2:0] op, logic [vmos_pkg::S_TDATA_W-1:0] word);
        if (burst_left == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge aclk);
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 120)
                                                     : $urandom_range(1, 16);
        end
        s_tuser  <= op;
        s_tdata  <= word;
        s_tvalid <= 1'b1;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
        requests_sent++;
    endtask

    // Fields an operation does not use carry random content.
    task automatic do_push(logic [31:0] v);
        send_req(vmos_pkg::OP_PUSH, pack_req(v, 9'($urandom), 5'($urandom), 31'($urandom),
                                             1'($urandom)));
    endtask

    task automatic do_peek(logic [8:0] off);
        send_req(vmos_pkg::OP_PEEK, pack_req($urandom, off, 5'($urandom), 31'($urandom),
                                             1'($urandom)));
    endtask

    task automatic do_pop_many(logic [4:0] cnt);
        send_req(vmos_pkg::OP_POP_MANY, pack_req($urandom, 9'($urandom), cnt, 31'($urandom),
                                                 1'($urandom)));
    endtask

    task automatic do_push_frame(logic [30:0] tgt, logic hf);
        send_req(vmos_pkg::OP_PUSH_FRM, pack_req($urandom, 9'($urandom), 5'($urandom), tgt,
                                                 hf));
    endtask

    task automatic do_simple(logic [2:0] op);
        send_req(op, pack_req($urandom, 9'($urandom), 5'($urandom), 31'($urandom),
                              1'($urandom)));
    endtask

    task automatic random_op();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 34)
            do_push($urandom);
        else if (pick < 44)
            do_simple(vmos_pkg::OP_POP);
        else if (pick < 58)
            do_peek(($urandom_range(0, 3) == 0) ? 9'($urandom) : 9'($urandom_range(1, 8)));
        else if (pick < 68)
            do_pop_many(($urandom_range(0, 3) == 0) ? 5'($urandom)
                                                    : 5'($urandom_range(1, 4)));
        else if (pick < 80)
            do_push_frame(31'($urandom), 1'($urandom));
        else if (pick < 88)
            do_simple(vmos_pkg::OP_POP_FRM);
        else if (pick < 96)
            do_simple(vmos_pkg::OP_UNWIND);
        else
            do_simple(OP_UNUSED);
    endtask

    // Nested frames with a few values each, then one or more removed again; popping values below a
    // frame's base first makes its removal refill the stack.
    task automatic frame_episode();
        int nest;
        nest = $urandom_range(1, 4);
        repeat (nest) begin
            do_push_frame(31'($urandom), 1'($urandom));
            repeat ($urandom_range(0, 5)) do_push($urandom);
            if ($urandom_range(0, 2) == 0) do_peek(9'($urandom_range(1, 4)));
        end
        if ($urandom_range(0, 2) == 0) do_pop_many(5'($urandom_range(1, 8)));
        repeat ($urandom_range(1, nest)) begin
            do_simple($urandom_range(0, 1) ? vmos_pkg::OP_UNWIND : vmos_pkg::OP_POP_FRM);
            if ($urandom_range(0, 3) == 0) do_peek(9'($urandom_range(1, 3)));
        end
    endtask

    initial begin : stimulus
        bit filled;
        filled = 1'b0;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Errors and empty-stack cases first.
        do_simple(vmos_pkg::OP_POP);
        do_peek(9'd1);
        do_pop_many(5'd0);
        do_pop_many(5'd1);
        do_simple(vmos_pkg::OP_POP_FRM);
        do_simple(vmos_pkg::OP_UNWIND);
        do_simple(OP_UNUSED);
        do_push(32'h7FFF_FFFF);
        do_push(32'h8000_0000);
        do_push(32'hFFFF_FFFF);
        do_push(32'h0000_0000);
        do_peek(9'd0);
        do_peek(9'd4);
        do_peek(9'h1FF);
        do_push_frame(31'h7FFF_FFFF, 1'b1);
        do_push(32'h5555_AAAA);
        do_push_frame(31'h0000_0000, 1'b0);
        do_pop_many(5'd31);
        do_pop_many(5'd17);
        do_pop_many(5'd3);
        // Unwinding passes the plain frame, whose base lies above the current depth.
        do_simple(vmos_pkg::OP_UNWIND);
        do_peek(9'd2);
        do_push_frame(31'h2AD5_5A2A, 1'b1);
        do_pop_many(5'd4);
        do_simple(vmos_pkg::OP_POP_FRM);

        while (requests_sent < DIRECTED_ITEMS + RANDOM_ITEMS) begin
            if (!filled && requests_sent > FILL_AFTER) begin
                filled = 1'b1;
                hold_requests++;
                repeat (vmos_pkg::VALUE_DEPTH + 2) do_push($urandom);
                do_peek(9'(vmos_pkg::VALUE_DEPTH));
                do_peek(9'(vmos_pkg::VALUE_DEPTH + 1));
                repeat (vmos_pkg::FRAME_DEPTH + 1) do_push_frame(31'($urandom), 1'($urandom));
                do_simple(vmos_pkg::OP_UNWIND);
                hold_requests++;
                repeat (vmos_pkg::VALUE_DEPTH / vmos_pkg::MAX_POP_MANY)
                    do_pop_many(5'(vmos_pkg::MAX_POP_MANY));
                // The frame on top was pushed on a full stack, so this refills all of it.
                do_simple(vmos_pkg::OP_POP_FRM);
                do_peek(9'd1);
                repeat (vmos_pkg::FRAME_DEPTH + 1) do_simple(vmos_pkg::OP_POP_FRM);
                do_pop_many(5'(vmos_pkg::MAX_POP_MANY));
            end else if ($urandom_range(0, 9) < 6) begin
                repeat ($urandom_range(4, 16)) random_op();
            end else begin
                frame_episode();
            end
        end
        s_tvalid <= 1'b0;

        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (fail_count == 0 && results_owed == 0)
            $display("vm_operand_stack_with_frames: match");
        else
            $display("vm_operand_stack_with_frames: mismatch");
        $finish;
    end

endmodule
